// ===== sv/gfa_pkg.sv =====
// shared types and constants for the gravity force accumulator
package gfa_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_OWN_POS_X     = 3'd0,
        CFG_OWN_POS_Y     = 3'd1,
        CFG_OWN_POS_Z     = 3'd2,
        CFG_OWN_MASS      = 3'd3,
        CFG_OWN_DIAMETER  = 3'd4,
        CFG_GRAV_CONSTANT = 3'd5
    } cfg_index_t;

    localparam int CFG_ADDR_W  = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic signed [47:0] FORCE_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] FORCE_MIN = 48'sh8000_0000_0000;

    // configuration register file contents
    typedef struct packed {
        logic signed [31:0] own_pos_x;
        logic signed [31:0] own_pos_y;
        logic signed [31:0] own_pos_z;
        logic [31:0]        own_mass;
        logic [31:0]        own_diameter;
        logic [31:0]        grav_constant;
    } cfg_t;

    // classified body waiting for the arithmetic back end
    typedef struct packed {
        logic [32:0] mag_x;
        logic [32:0] mag_y;
        logic [32:0] mag_z;
        logic        neg_x;
        logic        neg_y;
        logic        neg_z;
        logic [31:0] other_mass;
        logic [32:0] diam_sum;
        logic        has_gravity;
        logic        zero_dist;
        logic        last_body;
    } entry_t;

    // one result beat
    typedef struct packed {
        logic signed [47:0] pair_force_x;
        logic signed [47:0] pair_force_y;
        logic signed [47:0] pair_force_z;
        logic               merge_hit;
        logic signed [47:0] total_force_x;
        logic signed [47:0] total_force_y;
        logic signed [47:0] total_force_z;
        logic               frame_done;
    } result_t;

    // back end sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCALE,
        ST_QSET,
        ST_QDIV,
        ST_CMUL,
        ST_CSET,
        ST_CDIV,
        ST_OUT
    } back_state_t;

endpackage

// ===== sv/gfa_front.sv =====
// front end: offset vector, magnitudes and classification of one body
module gfa_front (
    input  gfa_pkg::cfg_t       cfg,
    input  logic signed [31:0]  other_pos_x,
    input  logic signed [31:0]  other_pos_y,
    input  logic signed [31:0]  other_pos_z,
    input  logic [31:0]         other_mass,
    input  logic [31:0]         other_diameter,
    input  logic                has_gravity,
    input  logic                last_body,
    output gfa_pkg::entry_t     entry
);
    import gfa_pkg::*;

    logic [32:0] dx, dy, dz;

    // 33-bit offsets in centimetres
    assign dx = {other_pos_x[31], other_pos_x} - {cfg.own_pos_x[31], cfg.own_pos_x};
    assign dy = {other_pos_y[31], other_pos_y} - {cfg.own_pos_y[31], cfg.own_pos_y};
    assign dz = {other_pos_z[31], other_pos_z} - {cfg.own_pos_z[31], cfg.own_pos_z};

    // split into sign and magnitude, flag coincident bodies
    always_comb begin
        entry.neg_x       = dx[32];
        entry.neg_y       = dy[32];
        entry.neg_z       = dz[32];
        entry.mag_x       = dx[32] ? (~dx + 33'd1) : dx;
        entry.mag_y       = dy[32] ? (~dy + 33'd1) : dy;
        entry.mag_z       = dz[32] ? (~dz + 33'd1) : dz;
        entry.other_mass  = other_mass;
        entry.diam_sum    = {1'b0, cfg.own_diameter} + {1'b0, other_diameter};
        entry.has_gravity = has_gravity;
        entry.zero_dist   = (dx == '0) && (dy == '0) && (dz == '0);
        entry.last_body   = last_body;
    end

endmodule

// ===== sv/gfa_queue.sv =====
// short queue between front and back end
module gfa_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  gfa_pkg::entry_t push_entry,
    output logic            not_full,
    input  logic            pop,
    output gfa_pkg::entry_t pop_entry,
    output logic            not_empty
);
    import gfa_pkg::*;

    entry_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               do_push, do_pop;

    assign not_full  = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign pop_entry = slot_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (do_push && !do_pop)      count_reg <= count_reg + QCNT_W'(1);
            else if (!do_push && do_pop) count_reg <= count_reg - QCNT_W'(1);
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// ===== sv/gfa_back.sv =====
// back end: shared multiplier, iterative dividers and square root, totals
module gfa_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  gfa_pkg::cfg_t    cfg,
    input  logic             q_valid,
    input  gfa_pkg::entry_t  q_entry,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output gfa_pkg::result_t result
);
    import gfa_pkg::*;

    back_state_t        state_reg, state_next;
    logic [6:0]         cnt_reg;
    entry_t             cur_reg;
    logic [65:0]        sq_reg;
    logic [79:0]        lim_reg;
    logic [63:0]        p1_reg;
    logic [109:0]       num_reg;
    logic               movf_reg;
    logic [65:0]        mrem_reg;
    logic [89:0]        mquo_reg;
    logic [69:0]        ssrc_reg;
    logic [38:0]        srem_reg;
    logic [34:0]        sroot_reg;
    logic [1:0]         axis_reg, chunk_reg;
    logic [122:0]       nc_reg   [3];
    logic [34:0]        crem_reg [3];
    logic [46:0]        cquo_reg [3];
    logic               covf_reg [3];
    result_t            res_reg;
    logic               out_valid_reg;
    logic signed [47:0] sum_x_reg, sum_y_reg, sum_z_reg;

    logic [33:0]        mul_a, mul_b;
    logic [67:0]        mul_p;
    logic               load_out;
    logic [66:0]        mt;
    logic               mge;
    logic [38:0]        st, strial;
    logic               sge;
    logic [35:0]        ct  [3];
    logic               cge [3];
    logic [89:0]        m_val;
    logic [109:0]       num_x100, lim_x100;
    logic signed [47:0] fx, fy, fz, tx, ty, tz;
    logic               force_on, hit;

    function automatic logic [109:0] x100(input logic [109:0] x);
        return (x << 6) + (x << 5) + (x << 2);
    endfunction

    function automatic logic signed [47:0] sat_add(input logic signed [47:0] a,
                                                   input logic signed [47:0] b);
        logic [48:0] s;
        s = {a[47], a} + {b[47], b};
        if (s[48] != s[47]) return s[48] ? FORCE_MIN : FORCE_MAX;
        return s[47:0];
    endfunction

    function automatic logic signed [47:0] signed_comp(input logic ovf,
                                                       input logic [46:0] quo,
                                                       input logic neg);
        logic [47:0] mag;
        mag = {1'b0, ovf ? {47{1'b1}} : quo};
        return neg ? -mag : mag;
    endfunction

    assign mul_p = mul_a * mul_b;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (q_valid) state_next = ST_MUL;
            ST_MUL:   if (cnt_reg == 7'd6) state_next = ST_SCALE;
            ST_SCALE: begin
                if (cnt_reg == 7'd1) begin
                    state_next = (cur_reg.has_gravity && !cur_reg.zero_dist) ? ST_QSET : ST_OUT;
                end
            end
            ST_QSET:  state_next = ST_QDIV;
            ST_QDIV:  if (cnt_reg == 7'd89) state_next = ST_CMUL;
            ST_CMUL:  if (axis_reg == 2'd2 && chunk_reg == 2'd2) state_next = ST_CSET;
            ST_CSET:  state_next = ST_CDIV;
            ST_CDIV:  if (cnt_reg == 7'd46) state_next = ST_OUT;
            ST_OUT:   if (load_out) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control outputs and multiplier operand select
    always_comb begin
        q_pop    = (state_reg == ST_IDLE) && q_valid;
        load_out = (state_reg == ST_OUT) && (!out_valid_reg || m_ready);
        mul_a    = '0;
        mul_b    = '0;
        case (state_reg)
            ST_MUL: begin
                case (cnt_reg)
                    7'd0: begin mul_a = {1'b0, cur_reg.mag_x}; mul_b = {1'b0, cur_reg.mag_x}; end
                    7'd1: begin mul_a = {1'b0, cur_reg.mag_y}; mul_b = {1'b0, cur_reg.mag_y}; end
                    7'd2: begin mul_a = {1'b0, cur_reg.mag_z}; mul_b = {1'b0, cur_reg.mag_z}; end
                    7'd3: begin
                        mul_a = {1'b0, cur_reg.diam_sum};
                        mul_b = {1'b0, cur_reg.diam_sum};
                    end
                    7'd4: begin mul_a = {2'b0, cfg.grav_constant}; mul_b = {2'b0, cfg.own_mass}; end
                    7'd5: begin mul_a = {2'b0, p1_reg[31:0]}; mul_b = {2'b0, cur_reg.other_mass}; end
                    default: begin
                        mul_a = {2'b0, p1_reg[63:32]};
                        mul_b = {2'b0, cur_reg.other_mass};
                    end
                endcase
            end
            ST_CMUL: begin
                case (chunk_reg)
                    2'd0:    mul_a = {4'b0, m_val[29:0]};
                    2'd1:    mul_a = {4'b0, m_val[59:30]};
                    default: mul_a = {4'b0, m_val[89:60]};
                endcase
                case (axis_reg)
                    2'd0:    mul_b = {1'b0, cur_reg.mag_x};
                    2'd1:    mul_b = {1'b0, cur_reg.mag_y};
                    default: mul_b = {1'b0, cur_reg.mag_z};
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divider, square root and result terms
    always_comb begin
        mt       = {mrem_reg, num_reg[89]};
        mge      = mt >= {1'b0, sq_reg};
        st       = {srem_reg[36:0], ssrc_reg[69:68]};
        strial   = {2'b0, sroot_reg, 2'b01};
        sge      = st >= strial;
        for (int i = 0; i < 3; i++) begin
            ct[i]  = {crem_reg[i], nc_reg[i][46]};
            cge[i] = ct[i] >= {1'b0, sroot_reg};
        end
        m_val    = movf_reg ? {90{1'b1}} : mquo_reg;
        num_x100 = x100(num_reg);
        lim_x100 = x100({30'b0, lim_reg});
        force_on = cur_reg.has_gravity && !cur_reg.zero_dist;
        fx       = force_on ? signed_comp(covf_reg[0], cquo_reg[0], cur_reg.neg_x) : '0;
        fy       = force_on ? signed_comp(covf_reg[1], cquo_reg[1], cur_reg.neg_y) : '0;
        fz       = force_on ? signed_comp(covf_reg[2], cquo_reg[2], cur_reg.neg_z) : '0;
        tx       = sat_add(sum_x_reg, fx);
        ty       = sat_add(sum_y_reg, fy);
        tz       = sat_add(sum_z_reg, fz);
        hit      = cur_reg.has_gravity && ({sq_reg, 34'b0} < {20'b0, lim_reg});
    end

    // control registers and running totals
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            sum_z_reg     <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= (state_next != state_reg) ? 7'd0 : cnt_reg + 7'd1;
            if (load_out) begin
                out_valid_reg <= 1'b1;
                sum_x_reg     <= cur_reg.last_body ? '0 : tx;
                sum_y_reg     <= cur_reg.last_body ? '0 : ty;
                sum_z_reg     <= cur_reg.last_body ? '0 : tz;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // arithmetic datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) cur_reg <= q_entry;
            end
            ST_MUL: begin
                case (cnt_reg)
                    7'd0:    sq_reg  <= mul_p[65:0];
                    7'd1:    sq_reg  <= sq_reg + mul_p[65:0];
                    7'd2:    sq_reg  <= sq_reg + mul_p[65:0];
                    7'd3:    lim_reg <= {14'b0, mul_p[65:0]};
                    7'd4:    p1_reg  <= mul_p[63:0];
                    7'd5:    num_reg <= {46'b0, mul_p[63:0]};
                    default: num_reg <= num_reg + {14'b0, mul_p[63:0], 32'b0};
                endcase
            end
            ST_SCALE: begin
                num_reg <= num_x100;
                lim_reg <= lim_x100[79:0];
            end
            ST_QSET: begin
                movf_reg  <= {46'b0, num_reg[109:90]} >= sq_reg;
                mrem_reg  <= {46'b0, num_reg[109:90]};
                ssrc_reg  <= {4'b0, sq_reg};
                srem_reg  <= '0;
                sroot_reg <= '0;
                axis_reg  <= '0;
                chunk_reg <= '0;
            end
            ST_QDIV: begin
                mrem_reg <= mge ? 66'(mt - {1'b0, sq_reg}) : mt[65:0];
                mquo_reg <= {mquo_reg[88:0], mge};
                num_reg  <= num_reg << 1;
                if (cnt_reg < 7'd35) begin
                    srem_reg  <= sge ? (st - strial) : st;
                    sroot_reg <= {sroot_reg[33:0], sge};
                    ssrc_reg  <= ssrc_reg << 2;
                end
            end
            ST_CMUL: begin
                for (int i = 0; i < 3; i++) begin
                    if (axis_reg == 2'(i)) begin
                        case (chunk_reg)
                            2'd0:    nc_reg[i] <= {60'b0, mul_p[62:0]};
                            2'd1:    nc_reg[i] <= nc_reg[i] + {30'b0, mul_p[62:0], 30'b0};
                            default: nc_reg[i] <= nc_reg[i] + {mul_p[62:0], 60'b0};
                        endcase
                    end
                end
                if (chunk_reg == 2'd2) begin
                    chunk_reg <= '0;
                    axis_reg  <= axis_reg + 2'd1;
                end else begin
                    chunk_reg <= chunk_reg + 2'd1;
                end
            end
            ST_CSET: begin
                for (int i = 0; i < 3; i++) begin
                    covf_reg[i] <= nc_reg[i][122:47] >= {41'b0, sroot_reg};
                    crem_reg[i] <= nc_reg[i][81:47];
                end
            end
            ST_CDIV: begin
                for (int i = 0; i < 3; i++) begin
                    crem_reg[i] <= cge[i] ? 35'(ct[i] - {1'b0, sroot_reg}) : ct[i][34:0];
                    cquo_reg[i] <= {cquo_reg[i][45:0], cge[i]};
                    nc_reg[i]   <= nc_reg[i] << 1;
                end
            end
            ST_OUT: begin
                if (load_out) begin
                    res_reg.pair_force_x  <= fx;
                    res_reg.pair_force_y  <= fy;
                    res_reg.pair_force_z  <= fz;
                    res_reg.merge_hit     <= hit;
                    res_reg.total_force_x <= tx;
                    res_reg.total_force_y <= ty;
                    res_reg.total_force_z <= tz;
                    res_reg.frame_done    <= cur_reg.last_body;
                end
            end
            default: ;
        endcase
    end

    assign m_valid = out_valid_reg;
    assign result  = res_reg;

endmodule

// ===== sv/gravity_force_accumulator.sv =====
// top level of the gravity force accumulator
// Takes the other bodies of a frame one beat at a time and returns, per body, the pair
// force on the configured body, a merge flag and the running force total; totals clear
// after the beat marked last_body. A body without gravity or at zero distance skips the dividers;
// any other body goes through the one-bit-per-cycle 90-step force magnitude divider and
// the three parallel 47-step component dividers (the distance square root runs beside
// the first divider). A two-entry queue lets input beats be taken while the back end is busy,
// and the result sits in an output register. Configuration must be written through
// cfg_valid/cfg_addr/cfg_data only while the block is idle; the block itself does not enforce this.
module gravity_force_accumulator (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gfa_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [31:0]                     cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [31:0]              s_other_pos_x,
    input  logic signed [31:0]              s_other_pos_y,
    input  logic signed [31:0]              s_other_pos_z,
    input  logic [31:0]                     s_other_mass,
    input  logic [31:0]                     s_other_diameter,
    input  logic                            s_has_gravity,
    input  logic                            s_last_body,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [47:0]              m_pair_force_x,
    output logic signed [47:0]              m_pair_force_y,
    output logic signed [47:0]              m_pair_force_z,
    output logic                            m_merge_hit,
    output logic signed [47:0]              m_total_force_x,
    output logic signed [47:0]              m_total_force_y,
    output logic signed [47:0]              m_total_force_z,
    output logic                            m_frame_done
);
    import gfa_pkg::*;

    cfg_t    cfg_reg;
    entry_t  front_entry, back_entry;
    logic    q_not_empty, q_pop;
    result_t result;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.own_pos_x     <= '0;
            cfg_reg.own_pos_y     <= '0;
            cfg_reg.own_pos_z     <= '0;
            cfg_reg.own_mass      <= 32'd1;
            cfg_reg.own_diameter  <= 32'd65536;
            cfg_reg.grav_constant <= 32'd65536;
        end else if (cfg_valid) begin
            case (cfg_addr)
                CFG_OWN_POS_X:     cfg_reg.own_pos_x     <= cfg_data;
                CFG_OWN_POS_Y:     cfg_reg.own_pos_y     <= cfg_data;
                CFG_OWN_POS_Z:     cfg_reg.own_pos_z     <= cfg_data;
                CFG_OWN_MASS:      cfg_reg.own_mass      <= cfg_data;
                CFG_OWN_DIAMETER:  cfg_reg.own_diameter  <= cfg_data;
                CFG_GRAV_CONSTANT: cfg_reg.grav_constant <= cfg_data;
                default: ;
            endcase
        end
    end

    gfa_front u_front (
        .cfg            (cfg_reg),
        .other_pos_x    (s_other_pos_x),
        .other_pos_y    (s_other_pos_y),
        .other_pos_z    (s_other_pos_z),
        .other_mass     (s_other_mass),
        .other_diameter (s_other_diameter),
        .has_gravity    (s_has_gravity),
        .last_body      (s_last_body),
        .entry          (front_entry)
    );

    gfa_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_valid),
        .push_entry (front_entry),
        .not_full   (s_ready),
        .pop        (q_pop),
        .pop_entry  (back_entry),
        .not_empty  (q_not_empty)
    );

    gfa_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_not_empty),
        .q_entry (back_entry),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .result  (result)
    );

    // result beat fields
    assign m_pair_force_x  = result.pair_force_x;
    assign m_pair_force_y  = result.pair_force_y;
    assign m_pair_force_z  = result.pair_force_z;
    assign m_merge_hit     = result.merge_hit;
    assign m_total_force_x = result.total_force_x;
    assign m_total_force_y = result.total_force_y;
    assign m_total_force_z = result.total_force_z;
    assign m_frame_done    = result.frame_done;

endmodule

// ===== sv/gfa_checker.sv =====
// port-level checks for the gravity force accumulator, bound to the top level
module gfa_port_checks (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [47:0] m_pair_force_x,
    input logic signed [47:0] m_pair_force_y,
    input logic signed [47:0] m_pair_force_z,
    input logic signed [47:0] m_total_force_x,
    input logic signed [47:0] m_total_force_y,
    input logic signed [47:0] m_total_force_z,
    input logic               m_frame_done
);
    import gfa_pkg::*;

    logic first_reg;

    // marks the first result beat of a frame
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b1;
        end else if (m_valid && m_ready) begin
            first_reg <= m_frame_done;
        end
    end

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_total_force_x)
            && $stable(m_pair_force_x) && $stable(m_frame_done))
        else $error("result beat changed while stalled");

    // totals start from zero at each frame
    a_frame_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && first_reg |-> m_total_force_x == m_pair_force_x
            && m_total_force_y == m_pair_force_y && m_total_force_z == m_pair_force_z)
        else $error("total not cleared at frame start");

    // pair force saturates symmetrically
    a_pair_sym: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_pair_force_x != FORCE_MIN && m_pair_force_y != FORCE_MIN
            && m_pair_force_z != FORCE_MIN)
        else $error("pair force at negative limit");

endmodule

bind gravity_force_accumulator gfa_port_checks u_gfa_port_checks (.*);

// ===== tb/sv/gfa_checker.sv =====
// result checker and force predictor for the gravity force accumulator
`timescale 1ns / 1ps

module gfa_checker
    import gfa_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [31:0]             cfg_data,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic signed [31:0]      s_other_pos_x,
    input  logic signed [31:0]      s_other_pos_y,
    input  logic signed [31:0]      s_other_pos_z,
    input  logic [31:0]             s_other_mass,
    input  logic [31:0]             s_other_diameter,
    input  logic                    s_has_gravity,
    input  logic                    s_last_body,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic signed [47:0]      m_pair_force_x,
    input  logic signed [47:0]      m_pair_force_y,
    input  logic signed [47:0]      m_pair_force_z,
    input  logic                    m_merge_hit,
    input  logic signed [47:0]      m_total_force_x,
    input  logic signed [47:0]      m_total_force_y,
    input  logic signed [47:0]      m_total_force_z,
    input  logic                    m_frame_done,
    output int                      errors,
    output int                      outstanding
);

    cfg_t                own;
    logic signed [47:0]  acc_x, acc_y, acc_z;
    result_t             expected_forces[$];

    assign outstanding = expected_forces.size();

    function automatic logic [127:0] abs_wide(input longint v);
        return (v < 0) ? 128'(-v) : 128'(v);
    endfunction

    // floor square root, distance fits in 35 bits
    function automatic logic [63:0] dist_root(input logic [127:0] sq);
        logic [63:0] root;
        logic [63:0] cand;
        root = '0;
        for (int b = 34; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (({64'd0, cand} * {64'd0, cand}) <= sq) root = cand;
        end
        return root;
    endfunction

    // one axis of the pair force, truncated toward zero and saturated
    function automatic logic signed [47:0] axis_force(input logic [127:0] mag, input longint d,
                                                      input logic [63:0] root);
        logic [127:0] q;
        logic signed [47:0] v;
        if (d == 0) return '0;
        q = (mag * abs_wide(d)) / {64'd0, root};
        v = (q > 128'(FORCE_MAX)) ? FORCE_MAX : $signed(q[47:0]);
        return (d < 0) ? -v : v;
    endfunction

    function automatic logic signed [47:0] sat_add(input logic signed [47:0] a,
                                                   input logic signed [47:0] b);
        logic signed [48:0] t;
        t = 49'(a) + 49'(b);
        if (t > 49'sh0_7FFF_FFFF_FFFF) return FORCE_MAX;
        if (t < -49'sh0_8000_0000_0000) return FORCE_MIN;
        return t[47:0];
    endfunction

    // pair force, merge flag and running total for one body
    function automatic result_t predict_body(input logic signed [31:0] px, py, pz,
                                             input logic [31:0] m2, d2,
                                             input logic grav, last);
        longint        dx, dy, dz;
        logic [127:0]  sq, lim, mag;
        logic [63:0]   root;
        result_t       res;
        dx = longint'(px) - longint'(own.own_pos_x);
        dy = longint'(py) - longint'(own.own_pos_y);
        dz = longint'(pz) - longint'(own.own_pos_z);
        res = '0;
        if (grav) begin
            sq = abs_wide(dx) * abs_wide(dx) + abs_wide(dy) * abs_wide(dy)
               + abs_wide(dz) * abs_wide(dz);
            lim = 128'(64'd100 * (64'(own.own_diameter) + 64'(d2)));
            lim = lim * lim;
            res.merge_hit = (sq << 34) < lim;
            if (sq != 0) begin
                mag = 128'(own.grav_constant) * 128'(own.own_mass) * 128'(m2) * 128'd10000;
                mag = mag / sq;
                if ((mag >> 90) != 0) mag = (128'd1 << 90) - 1;
                root = dist_root(sq);
                res.pair_force_x = axis_force(mag, dx, root);
                res.pair_force_y = axis_force(mag, dy, root);
                res.pair_force_z = axis_force(mag, dz, root);
            end
        end
        acc_x = sat_add(acc_x, res.pair_force_x);
        acc_y = sat_add(acc_y, res.pair_force_y);
        acc_z = sat_add(acc_z, res.pair_force_z);
        res.total_force_x = acc_x;
        res.total_force_y = acc_y;
        res.total_force_z = acc_z;
        res.frame_done = last;
        if (last) begin
            acc_x = '0;
            acc_y = '0;
            acc_z = '0;
        end
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [47:0] exp_v,
                                 input logic [47:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    initial errors = 0;

    // track config writes, predict on input beats, check result beats
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            own <= '{own_pos_x: 0, own_pos_y: 0, own_pos_z: 0, own_mass: 1,
                     own_diameter: 32'd65536, grav_constant: 32'd65536};
            acc_x = '0;
            acc_y = '0;
            acc_z = '0;
            expected_forces.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index_t'(cfg_addr))
                    CFG_OWN_POS_X:     own.own_pos_x     <= cfg_data;
                    CFG_OWN_POS_Y:     own.own_pos_y     <= cfg_data;
                    CFG_OWN_POS_Z:     own.own_pos_z     <= cfg_data;
                    CFG_OWN_MASS:      own.own_mass      <= cfg_data;
                    CFG_OWN_DIAMETER:  own.own_diameter  <= cfg_data;
                    CFG_GRAV_CONSTANT: own.grav_constant <= cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_forces.push_back(predict_body(s_other_pos_x, s_other_pos_y,
                    s_other_pos_z, s_other_mass, s_other_diameter, s_has_gravity,
                    s_last_body));
            if (m_valid && m_ready) begin
                if (expected_forces.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with no body pending", $time);
                end else begin
                    want = expected_forces.pop_front();
                    compare_field("pair_force_x", want.pair_force_x, m_pair_force_x);
                    compare_field("pair_force_y", want.pair_force_y, m_pair_force_y);
                    compare_field("pair_force_z", want.pair_force_z, m_pair_force_z);
                    compare_field("merge_hit", 48'(want.merge_hit), 48'(m_merge_hit));
                    compare_field("total_force_x", want.total_force_x, m_total_force_x);
                    compare_field("total_force_y", want.total_force_y, m_total_force_y);
                    compare_field("total_force_z", want.total_force_z, m_total_force_z);
                    compare_field("frame_done", 48'(want.frame_done), 48'(m_frame_done));
                end
            end
        end
    end

endmodule

// ===== tb/sv/tb_gravity_force_accumulator.sv =====
// stimulus, clocking and verdict for the gravity force accumulator
`timescale 1ns / 1ps

module tb_gravity_force_accumulator;
    import gfa_pkg::*;

    localparam int STALL_LIMIT = 6000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [31:0]           cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic signed [31:0]    s_other_pos_x = '0;
    logic signed [31:0]    s_other_pos_y = '0;
    logic signed [31:0]    s_other_pos_z = '0;
    logic [31:0]           s_other_mass = '0;
    logic [31:0]           s_other_diameter = '0;
    logic                  s_has_gravity = 1'b0;
    logic                  s_last_body = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic signed [47:0]    m_pair_force_x, m_pair_force_y, m_pair_force_z;
    logic signed [47:0]    m_total_force_x, m_total_force_y, m_total_force_z;
    logic                  m_merge_hit, m_frame_done;

    int errors, outstanding;
    int send_idle_pct = 26;
    int recv_idle_pct = 85;
    int stall_cycles = 0;
    logic signed [31:0] own_x, own_y, own_z;
    int frame_left = 0;

    always #5 aclk = ~aclk;

    gravity_force_accumulator i_dut (.*);

    gfa_checker i_checker (.*);

    // receiver back pressure
    always @(negedge aclk) m_ready <= ($urandom_range(99) >= recv_idle_pct);

    // watchdog on cycles with no beat on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_gravity_force_accumulator: FAIL");
            $finish;
        end else
            stall_cycles <= stall_cycles + 1;
    end

    // leaves s_valid high on return; caller sends again or drops it in the same step
    task automatic send_body(input logic signed [31:0] px, py, pz, input logic [31:0] m2, d2,
                             input logic grav, last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_other_pos_x    <= px;
        s_other_pos_y    <= py;
        s_other_pos_z    <= pz;
        s_other_mass     <= m2;
        s_other_diameter <= d2;
        s_has_gravity    <= grav;
        s_last_body      <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // stop sending and wait for every pending result
    task automatic drain();
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic load_body(input logic signed [31:0] px, py, pz,
                             input logic [31:0] mass, diam, g);
        write_reg(CFG_OWN_POS_X, px);
        write_reg(CFG_OWN_POS_Y, py);
        write_reg(CFG_OWN_POS_Z, pz);
        write_reg(CFG_OWN_MASS, mass);
        write_reg(CFG_OWN_DIAMETER, diam);
        write_reg(CFG_GRAV_CONSTANT, g);
        own_x = px;
        own_y = py;
        own_z = pz;
    endtask

    function automatic logic [31:0] rand_scaled();
        return $urandom >> $urandom_range(32);
    endfunction

    function automatic logic signed [31:0] near(input logic signed [31:0] c);
        return c + ($signed($urandom) >>> $urandom_range(31));
    endfunction

    // mostly well-formed frames of nearby bodies, some noise
    task automatic random_body();
        logic last;
        int kind;
        kind = $urandom_range(99);
        if (frame_left == 0) frame_left = $urandom_range(1, 8);
        frame_left--;
        last = (frame_left == 0);
        if (kind < 10)
            send_body($urandom, $urandom, $urandom, $urandom, $urandom, 1'($urandom), last);
        else if (kind < 20)
            send_body(near(own_x), near(own_y), near(own_z), rand_scaled(), rand_scaled(),
                      1'b0, last);
        else if (kind < 25)
            send_body(own_x, own_y, own_z, rand_scaled(), rand_scaled(), 1'b1, last);
        else
            send_body(near(own_x), near(own_y), near(own_z), rand_scaled(), rand_scaled(),
                      1'b1, last);
    endtask

    initial begin
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        own_x = 0;
        own_y = 0;
        own_z = 0;
        @(negedge aclk);

        // directed bodies against the reset configuration
        send_body(0, 0, 0, 5, 32'd65536, 1'b1, 1'b0);                    // zero distance
        send_body(100, 0, 0, 7, 0, 1'b0, 1'b0);                          // no gravity
        send_body(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '1, '1, 1'b1, 1'b0);
        send_body(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, '1, '1, 1'b1, 1'b0);
        send_body(100, 0, 0, '1, 0, 1'b1, 1'b0);                         // saturates
        send_body(-100, -200, 300, '1, 0, 1'b1, 1'b0);
        send_body(-100, 0, 0, 0, 32'd10, 1'b1, 1'b0);                    // zero mass
        send_body(3, -4, 12, 1000, 0, 1'b1, 1'b0);
        send_body(-3, 4, -12, 1000, 32'd65536, 1'b1, 1'b1);
        send_body(50, 50, 50, 123456, 0, 1'b1, 1'b1);
        drain();

        // extremes: own body at the corner, heaviest mass and constant, no diameter
        load_body(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, '1, 0, '1);
        send_body(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, '1, 0, 1'b1, 1'b0);
        send_body(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 9, 1, 1'b1, 1'b0);
        send_body(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '1, '1, 1'b1, 1'b0);
        send_body(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0001, 1, 0, 1'b1, 1'b0);
        send_body(32'sh8000_0001, 32'sh8000_0000, 32'sh8000_0000, '1, 0, 1'b0, 1'b1);
        send_body(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 2, '1, 1'b1, 1'b1);
        drain();

        // random phases across settings and idling patterns
        for (int phase = 0; phase < 6; phase++) begin
            case (phase / 2)
                0: begin send_idle_pct = 26; recv_idle_pct = 85; end
                1: begin send_idle_pct = 85; recv_idle_pct = 26; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            case (phase)
                0: load_body($urandom, $urandom, $urandom, rand_scaled(), rand_scaled(),
                             rand_scaled());
                1: load_body(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, '1, 0);
                2: load_body(0, 0, 0, 1, 32'd65536, 32'd65536);
                default: load_body($urandom, $urandom, $urandom, rand_scaled(),
                                   rand_scaled(), rand_scaled());
            endcase
            frame_left = 0;
            for (int n = 0; n < 138; n++) begin
                random_body();
                if (n == 70) drain();
            end
            drain();
        end

        drain();
        if (errors == 0)
            $display("tb_gravity_force_accumulator: PASS");
        else
            $display("tb_gravity_force_accumulator: FAIL");
        $finish;
    end

endmodule
